// ===== rtl/sawq_pkg.sv =====
// shared types, codes and constants for the stop-and-wait arq sender
package sawq_pkg;

  localparam int MAX_PAYLOAD = 10;
  localparam int PAYLOAD_LIM = (MAX_PAYLOAD > 10) ? 10 : MAX_PAYLOAD;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_ACK  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_SENT       = 3'd1;
  localparam logic [2:0] EV_RESENT_TMO = 3'd2;
  localparam logic [2:0] EV_RESENT_SUM = 3'd3;
  localparam logic [2:0] EV_RESENT_SEQ = 3'd4;
  localparam logic [2:0] EV_DONE       = 3'd5;
  localparam logic [2:0] EV_GAVEUP     = 3'd6;
  localparam logic [2:0] EV_REFUSED    = 3'd7;

  localparam logic CFG_MAX_RETRIES   = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         item_len;
    logic [63:0]        data_lo;
    logic [15:0]        data_hi;
    logic signed [31:0] ack_seq;
    logic signed [31:0] ack_cksum;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        event_kind;
    logic              tx_seq;
    logic [3:0]        tx_len;
    logic [63:0]       tx_data_lo;
    logic [15:0]       tx_data_hi;
    logic signed [7:0] tx_cksum;
    logic [3:0]        retry_number;
  } out_item_t;

  // classified item as it travels through the queue
  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  len_sat;
    logic [63:0] data_lo;
    logic [15:0] data_hi;
    logic [7:0]  pay_xor;
    logic        sum_ok;
    logic        seq_is0;
    logic        seq_is1;
  } class_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

// ===== rtl/sawq_front.sv =====
// front end: takes input transfers, trims payloads and checks ack checksums
module sawq_front (
  input  sawq_pkg::in_item_t    in_item,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sawq_pkg::queue_status_t q_status,
  output logic                  push,
  output sawq_pkg::class_item_t push_item
);

  logic [3:0]  len_sat;
  logic [79:0] raw_data;
  logic [79:0] kept_data;
  logic [7:0]  pay_xor;
  logic [7:0]  ack_sum;
  logic [31:0] ack_exp;

  assign raw_data = {in_item.data_hi, in_item.data_lo};
  assign len_sat  = (in_item.item_len > 4'(sawq_pkg::PAYLOAD_LIM)) ?
                    4'(sawq_pkg::PAYLOAD_LIM) : in_item.item_len;

  always_comb begin
    kept_data = '0;
    pay_xor   = '0;
    for (int i = 0; i < 10; i++) begin
      if (4'(i) < len_sat) begin
        kept_data[8*i +: 8] = raw_data[8*i +: 8];
        pay_xor             = pay_xor ^ raw_data[8*i +: 8];
      end
    end
  end

  // header bytes of the ack: seq word, raw length byte, checksum word taken as zero
  assign ack_sum = in_item.ack_seq[7:0] ^ in_item.ack_seq[15:8] ^ in_item.ack_seq[23:16] ^
                   in_item.ack_seq[31:24] ^ {4'b0, in_item.item_len} ^ pay_xor;
  assign ack_exp = {{24{ack_sum[7]}}, ack_sum};

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  always_comb begin
    push_item.req_type = in_item.req_type;
    push_item.len_sat  = len_sat;
    push_item.data_lo  = kept_data[63:0];
    push_item.data_hi  = kept_data[79:64];
    push_item.pay_xor  = pay_xor;
    push_item.sum_ok   = (32'(in_item.ack_cksum) == ack_exp);
    push_item.seq_is0  = (32'(in_item.ack_seq) == 32'd0);
    push_item.seq_is1  = (32'(in_item.ack_seq) == 32'd1);
  end

endmodule

// ===== rtl/sawq_queue.sv =====
// short queue between front end and back end
module sawq_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  sawq_pkg::class_item_t   push_item,
  input  logic                    pop,
  output sawq_pkg::class_item_t   head_item,
  output sawq_pkg::queue_status_t q_status
);

  localparam int DEPTH = sawq_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  sawq_pkg::class_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item      = mem_r[rd_ptr_r];
  assign q_status.valid = (count_r != '0);
  assign q_status.full  = (count_r == CW'(DEPTH));

endmodule

// ===== rtl/sawq_back.sv =====
// back end: sender state, response timer, retry count and result register
module sawq_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [15:0]             cfg_wdata,
  input  sawq_pkg::class_item_t   head_item,
  input  sawq_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output sawq_pkg::out_item_t     out_item
);

  logic [3:0]  max_retries_r;
  logic [15:0] timeout_r;

  logic        waiting_r, waiting_nxt;
  logic        seq_r, seq_nxt;
  logic [3:0]  retry_r, retry_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [3:0]  held_len_r, held_len_nxt;
  logic [63:0] held_lo_r, held_lo_nxt;
  logic [15:0] held_hi_r, held_hi_nxt;
  logic [7:0]  held_cksum_r, held_cksum_nxt;

  logic                out_valid_r, out_valid_nxt;
  sawq_pkg::out_item_t out_item_r, out_item_nxt;

  logic [2:0]  ev;
  logic        tx;
  logic [15:0] timer_inc;
  logic [3:0]  retry_inc;
  logic        seq_match;

  assign pop = q_status.valid && (!out_valid_r || !out_stall);

  assign timer_inc = (timer_r == 16'hFFFF) ? 16'hFFFF : timer_r + 16'd1;
  assign retry_inc = (retry_r == 4'hF) ? 4'hF : retry_r + 4'd1;
  assign seq_match = seq_r ? head_item.seq_is1 : head_item.seq_is0;

  always_comb begin
    waiting_nxt    = waiting_r;
    seq_nxt        = seq_r;
    retry_nxt      = retry_r;
    timer_nxt      = timer_r;
    held_len_nxt   = held_len_r;
    held_lo_nxt    = held_lo_r;
    held_hi_nxt    = held_hi_r;
    held_cksum_nxt = held_cksum_r;
    ev             = sawq_pkg::EV_NONE;
    tx             = 1'b0;
    case (head_item.req_type)
      sawq_pkg::REQ_SEND: begin
        if (waiting_r) begin
          ev = sawq_pkg::EV_REFUSED;
        end else begin
          ev             = sawq_pkg::EV_SENT;
          tx             = 1'b1;
          held_len_nxt   = head_item.len_sat;
          held_lo_nxt    = head_item.data_lo;
          held_hi_nxt    = head_item.data_hi;
          held_cksum_nxt = {7'b0, seq_r} ^ {4'b0, head_item.len_sat} ^ head_item.pay_xor;
          retry_nxt      = '0;
          timer_nxt      = '0;
          waiting_nxt    = 1'b1;
        end
      end
      sawq_pkg::REQ_ACK: begin
        if (!waiting_r) begin
          ev = sawq_pkg::EV_REFUSED;
        end else if (!head_item.sum_ok) begin
          ev        = sawq_pkg::EV_RESENT_SUM;
          tx        = 1'b1;
          timer_nxt = '0;
        end else if (!seq_match) begin
          ev        = sawq_pkg::EV_RESENT_SEQ;
          tx        = 1'b1;
          timer_nxt = '0;
        end else begin
          ev          = sawq_pkg::EV_DONE;
          waiting_nxt = 1'b0;
          seq_nxt     = ~seq_r;
          timer_nxt   = '0;
        end
      end
      sawq_pkg::REQ_TICK: begin
        if (waiting_r) begin
          if (timer_inc >= timeout_r) begin
            retry_nxt = retry_inc;
            timer_nxt = '0;
            if (retry_inc >= max_retries_r) begin
              ev          = sawq_pkg::EV_GAVEUP;
              waiting_nxt = 1'b0;
              seq_nxt     = ~seq_r;
            end else begin
              ev = sawq_pkg::EV_RESENT_TMO;
              tx = 1'b1;
            end
          end else begin
            timer_nxt = timer_inc;
          end
        end
      end
      default: begin
        ev = sawq_pkg::EV_NONE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (pop) begin
      out_valid_nxt             = 1'b1;
      out_item_nxt.event_kind   = ev;
      out_item_nxt.tx_seq       = tx ? seq_r : 1'b0;
      out_item_nxt.tx_len       = tx ? held_len_nxt : 4'd0;
      out_item_nxt.tx_data_lo   = tx ? held_lo_nxt : 64'd0;
      out_item_nxt.tx_data_hi   = tx ? held_hi_nxt : 16'd0;
      out_item_nxt.tx_cksum     = tx ? held_cksum_nxt : 8'd0;
      out_item_nxt.retry_number = retry_nxt;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= 4'd3;
      timeout_r     <= 16'd1000;
      waiting_r     <= 1'b0;
      seq_r         <= 1'b0;
      retry_r       <= '0;
      timer_r       <= '0;
      held_len_r    <= '0;
      held_cksum_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == sawq_pkg::CFG_MAX_RETRIES) begin
        max_retries_r <= cfg_wdata[3:0];
      end
      if (cfg_we && cfg_index == sawq_pkg::CFG_TIMEOUT_TICKS) begin
        timeout_r <= cfg_wdata;
      end
      if (pop) begin
        waiting_r    <= waiting_nxt;
        seq_r        <= seq_nxt;
        retry_r      <= retry_nxt;
        timer_r      <= timer_nxt;
        held_len_r   <= held_len_nxt;
        held_cksum_r <= held_cksum_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      held_lo_r <= held_lo_nxt;
      held_hi_r <= held_hi_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/stop_and_wait_arq_sender.sv =====
// top level of the alternating-bit stop-and-wait arq sender
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   sawq_pkg::in_item_t
//   out_     output     out_valid/out_stall sawq_pkg::out_item_t
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// one item per cycle sustained without out_stall; each transfer gives one result,
// registered first in the two-entry queue and then in the result register.
// the back end handles one queued item per cycle unless stalled, by one state update.
// synchronous active-low reset: sender idle, sequence bit 0, retries 3, timeout 1000.
// out_stall holds the result register; the queue then fills and raises in_stall.
module stop_and_wait_arq_sender (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sawq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sawq_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);

  sawq_pkg::queue_status_t q_status;
  sawq_pkg::class_item_t   push_item;
  sawq_pkg::class_item_t   head_item;
  logic                    push;
  logic                    pop;

  sawq_front u_front (
    .in_item   (in_item),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  sawq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_status  (q_status)
  );

  sawq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head_item (head_item),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the stop-and-wait arq sender, with a scoreboard class
module tb;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int SETTLE_CYCLES = 6;

  class arq_checker;
    bit [3:0]  max_retries = 4'd3;
    bit [15:0] timeout_ticks = 16'd1000;
    bit        waiting;
    bit        cur_seq;
    bit [3:0]  retry_cnt;
    bit [15:0] timer_cnt;
    bit [3:0]  held_len;
    bit [79:0] held_data;
    bit [7:0]  held_sum;
    sawq_pkg::out_item_t pending_events[$];
    int        errors;

    function void set_config(bit [3:0] retries, bit [15:0] ticks);
      max_retries = retries;
      timeout_ticks = ticks;
    endfunction

    function int sat_len(bit [3:0] len);
      return (len > sawq_pkg::PAYLOAD_LIM) ? sawq_pkg::PAYLOAD_LIM : int'(len);
    endfunction

    function bit [7:0] payload_xor(bit [79:0] data, int n);
      bit [7:0] x;
      x = 8'd0;
      for (int i = 0; i < n && i < 10; i++) x ^= data[8*i +: 8];
      return x;
    endfunction

    // checksum an ack must carry: header bytes (seq, len) and at most ten payload bytes
    function bit [31:0] ack_sum(bit [31:0] seq, bit [3:0] len, bit [79:0] data);
      bit [7:0] e;
      e = seq[7:0] ^ seq[15:8] ^ seq[23:16] ^ seq[31:24] ^ {4'd0, len}
          ^ payload_xor(data, sat_len(len));
      return {{24{e[7]}}, e};
    endfunction

    function sawq_pkg::out_item_t report(bit [2:0] ev, bit tx);
      sawq_pkg::out_item_t r;
      r = '0;
      r.event_kind = ev;
      if (tx) begin
        r.tx_seq = cur_seq;
        r.tx_len = held_len;
        r.tx_data_lo = held_data[63:0];
        r.tx_data_hi = held_data[79:64];
        r.tx_cksum = held_sum;
      end
      r.retry_number = retry_cnt;
      return r;
    endfunction

    function void note_request(sawq_pkg::in_item_t it);
      bit [79:0] data;
      int        n;
      bit [16:0] t;
      sawq_pkg::out_item_t r;
      data = {it.data_hi, it.data_lo};
      r = report(sawq_pkg::EV_NONE, 1'b0);
      case (it.req_type)
        sawq_pkg::REQ_SEND: begin
          if (waiting) begin
            r = report(sawq_pkg::EV_REFUSED, 1'b0);
          end else begin
            n = sat_len(it.item_len);
            held_len = n[3:0];
            // bytes beyond the length are dropped
            held_data = data & ((80'd1 << (8 * n)) - 80'd1);
            held_sum = {7'd0, cur_seq} ^ {4'd0, held_len} ^ payload_xor(held_data, n);
            retry_cnt = 4'd0;
            timer_cnt = 16'd0;
            waiting = 1'b1;
            r = report(sawq_pkg::EV_SENT, 1'b1);
          end
        end
        sawq_pkg::REQ_ACK: begin
          if (!waiting) begin
            r = report(sawq_pkg::EV_REFUSED, 1'b0);
          end else if (it.ack_cksum != ack_sum(it.ack_seq, it.item_len, data)) begin
            timer_cnt = 16'd0;
            r = report(sawq_pkg::EV_RESENT_SUM, 1'b1);
          end else if (it.ack_seq != {31'd0, cur_seq}) begin
            timer_cnt = 16'd0;
            r = report(sawq_pkg::EV_RESENT_SEQ, 1'b1);
          end else begin
            waiting = 1'b0;
            cur_seq = ~cur_seq;
            timer_cnt = 16'd0;
            r = report(sawq_pkg::EV_DONE, 1'b0);
          end
        end
        sawq_pkg::REQ_TICK: begin
          if (waiting) begin
            t = {1'b0, timer_cnt} + 17'd1;
            timer_cnt = (t > 17'h0FFFF) ? 16'hFFFF : t[15:0];
            if (timer_cnt >= timeout_ticks) begin
              if (retry_cnt != 4'hF) retry_cnt++;
              timer_cnt = 16'd0;
              if (retry_cnt >= max_retries) begin
                waiting = 1'b0;
                cur_seq = ~cur_seq;
                r = report(sawq_pkg::EV_GAVEUP, 1'b0);
              end else begin
                r = report(sawq_pkg::EV_RESENT_TMO, 1'b1);
              end
            end
          end
        end
        default: ;
      endcase
      pending_events.push_back(r);
    endfunction

    function void compare(string field, logic [79:0] want, logic [79:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_event(sawq_pkg::out_item_t got);
      sawq_pkg::out_item_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: result with none expected, expected nothing got %h", $time, got);
        errors++;
      end else begin
        want = pending_events.pop_front();
        compare("event_kind", want.event_kind, got.event_kind);
        compare("tx_seq", want.tx_seq, got.tx_seq);
        compare("tx_len", want.tx_len, got.tx_len);
        compare("tx_data_lo", want.tx_data_lo, got.tx_data_lo);
        compare("tx_data_hi", want.tx_data_hi, got.tx_data_hi);
        compare("tx_cksum", {want.tx_cksum}, {got.tx_cksum});
        compare("retry_number", want.retry_number, got.retry_number);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  sawq_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  sawq_pkg::out_item_t out_item;
  logic                cfg_we;
  logic                cfg_index;
  logic [15:0]         cfg_wdata;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_req = 1'b0;
  arq_checker chk = new();

  stop_and_wait_arq_sender u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random stall bursts, or one long hold-off on request
  initial begin : out_stall_gen
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) chk.check_event(out_item);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic logic [79:0] rand_data();
    return {16'($urandom), $urandom, $urandom};
  endfunction

  function automatic logic [3:0] rand_len();
    if ($urandom_range(0, 9) < 8) return 4'($urandom_range(0, sawq_pkg::PAYLOAD_LIM));
    return 4'($urandom_range(sawq_pkg::PAYLOAD_LIM + 1, 15));
  endfunction

  function automatic sawq_pkg::in_item_t make_item(logic [1:0] req, logic [3:0] len,
                                                   logic [79:0] data, logic [31:0] seq,
                                                   logic [31:0] sum);
    sawq_pkg::in_item_t it;
    it.req_type = req;
    it.item_len = len;
    it.data_lo = data[63:0];
    it.data_hi = data[79:64];
    it.ack_seq = seq;
    it.ack_cksum = sum;
    return it;
  endfunction

  function automatic sawq_pkg::in_item_t send_req(logic [3:0] len, logic [79:0] data);
    return make_item(sawq_pkg::REQ_SEND, len, data, $urandom, $urandom);
  endfunction

  function automatic sawq_pkg::in_item_t tick_req();
    return make_item(sawq_pkg::REQ_TICK, rand_len(), rand_data(), $urandom, $urandom);
  endfunction

  // ack with a matching checksum for whatever sequence field it carries
  function automatic sawq_pkg::in_item_t ack_with_seq(logic [31:0] seq, logic [3:0] len,
                                                      logic [79:0] data);
    return make_item(sawq_pkg::REQ_ACK, len, data, seq, chk.ack_sum(seq, len, data));
  endfunction

  function automatic sawq_pkg::in_item_t good_ack(logic [3:0] len, logic [79:0] data);
    return ack_with_seq({31'd0, chk.cur_seq}, len, data);
  endfunction

  function automatic sawq_pkg::in_item_t random_item();
    int          pick;
    logic [3:0]  len;
    logic [79:0] data;
    logic [31:0] seq;
    logic [31:0] sum;
    pick = $urandom_range(0, 99);
    len = rand_len();
    data = rand_data();
    if (!chk.waiting) begin
      if (pick < 65) return send_req(len, data);
      if (pick < 73) return ack_with_seq({31'd0, 1'($urandom)}, len, data);
      if (pick < 88) return tick_req();
      return make_item(REQ_SPARE, len, data, $urandom, $urandom);
    end
    if (pick < 40) return tick_req();
    if (pick < 75) return good_ack(len, data);
    if (pick < 83) begin
      seq = {31'd0, chk.cur_seq};
      sum = chk.ack_sum(seq, len, data) ^ (32'd1 << $urandom_range(0, 31));
      if ($urandom_range(0, 3) == 0) sum = $urandom;
      return make_item(sawq_pkg::REQ_ACK, len, data, seq, sum);
    end
    if (pick < 90) begin
      seq = $urandom_range(0, 1) ? {31'd0, ~chk.cur_seq} : $urandom;
      return ack_with_seq(seq, len, data);
    end
    if (pick < 95) return send_req(len, data);
    return make_item(REQ_SPARE, len, data, $urandom, $urandom);
  endfunction

  task automatic drive_item(input sawq_pkg::in_item_t it);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    chk.note_request(it);
  endtask

  task automatic write_config(input logic [3:0] retries, input logic [15:0] ticks);
    cfg_we <= 1'b1;
    cfg_index <= sawq_pkg::CFG_MAX_RETRIES;
    cfg_wdata <= {12'd0, retries};
    @(posedge clk);
    cfg_index <= sawq_pkg::CFG_TIMEOUT_TICKS;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.set_config(retries, ticks);
  endtask

  // stop offering and let every expected result drain out
  task automatic settle();
    in_valid <= 1'b0;
    while (chk.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    sawq_pkg::in_item_t it;
    int          done_items;
    bit          counted;
    logic [3:0]  retries;
    logic [15:0] ticks;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= sawq_pkg::CFG_MAX_RETRIES;
    cfg_wdata <= 16'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle corner cases on reset settings
    drive_item(make_item(sawq_pkg::REQ_TICK, 4'd0, '0, '0, '0));
    drive_item(make_item(REQ_SPARE, 4'hF, '1, '1, '1));
    drive_item(good_ack(4'd3, rand_data()));
    settle();
    write_config(4'd2, 16'd2);
    drive_item(send_req(4'd0, '1));
    drive_item(send_req(4'd5, rand_data()));
    // checksum field outside the byte range can never match
    drive_item(make_item(sawq_pkg::REQ_ACK, 4'd0, '0, {31'd0, chk.cur_seq}, 32'h0000_1000));
    drive_item(ack_with_seq({31'd0, ~chk.cur_seq}, 4'd0, '0));
    repeat (4) drive_item(tick_req());
    drive_item(send_req(4'd10, '1));
    drive_item(good_ack(4'd10, '1));
    drive_item(send_req(4'd15, rand_data()));
    drive_item(good_ack(4'd15, rand_data()));
    drive_item(send_req(4'd1, 80'h80));
    drive_item(ack_with_seq(32'hFFFF_FFFF, 4'd1, 80'h80));
    drive_item(good_ack(4'd1, 80'h80));
    drive_item(send_req(4'd9, '1));
    drive_item(good_ack(4'd12, rand_data()));
    drive_item(send_req(4'd8, rand_data()));
    drive_item(make_item(sawq_pkg::REQ_ACK, 4'd8, rand_data(), $urandom, $urandom));
    drive_item(good_ack(4'd8, rand_data()));

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin retries = 4'd15; ticks = 16'd1; in_idle_pct = 20; out_idle_pct = 8; end
        1: begin retries = 4'd1; ticks = 16'hFFFF; in_idle_pct = 0; out_idle_pct = 0; end
        2: begin retries = 4'd2; ticks = 16'd3; in_idle_pct = 0; out_idle_pct = 5; end
        3: begin retries = 4'd1; ticks = 16'd1; in_idle_pct = 10; out_idle_pct = 15; end
        4: begin
          retries = 4'($urandom_range(1, 15));
          ticks = 16'($urandom_range(1, 6));
          in_idle_pct = 15;
          out_idle_pct = 8;
        end
        default: begin
          retries = 4'($urandom_range(1, 15));
          ticks = 16'($urandom_range(1, 4));
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      write_config(retries, ticks);
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        it = random_item();
        // idle ticks and spare requests leave the sender untouched
        counted = !(it.req_type == REQ_SPARE ||
                    (it.req_type == sawq_pkg::REQ_TICK && !chk.waiting));
        drive_item(it);
        if (counted) begin
          done_items++;
          if (ph == 2 && done_items == 30) hold_req = 1'b1;
          if (ph == 4 && done_items == 45) settle();
        end
      end
    end

    settle();
    if (chk.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
